// ===== hw/rtl/xs256_pkg.sv =====
// Package for the xoshiro256** generator: constants, operation codes and helpers.
// Used by xoshiro256ss_generator; depends on nothing else.

package xs256_pkg;

   localparam int WORD_W = 64;
   localparam int HALF_W = 32;
   localparam int FRAC_W = 53;

   localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
   localparam logic [WORD_W-1:0] INIT_WORD3   = 64'h2545_F491_4F6C_DD1D;

   // Twice the golden-ratio constant, modulo 2^64.
   localparam logic [WORD_W-1:0] SEED_OFFSET  = 64'h3C6E_F372_FE94_F82A;

   localparam logic OP_DRAW   = 1'b0;
   localparam logic OP_RESEED = 1'b1;

   function automatic logic [WORD_W-1:0] rotl45(input logic [WORD_W-1:0] v);
      rotl45 = {v[18:0], v[63:19]};
   endfunction

   function automatic logic [WORD_W-1:0] rotl7(input logic [WORD_W-1:0] v);
      rotl7 = {v[56:0], v[63:57]};
   endfunction

endpackage

// ===== hw/rtl/xoshiro256ss_generator.sv =====
// xoshiro256** generator with splitmix64 reseeding and one shared 32x32 multiplier.
// Depends on xs256_pkg.

// A draw word (opcode 0) returns one result word through the DRAW_A and DRAW_B states,
// and DRAW_B waits while the result register is still held by rsp_ready low. A reseed
// word (opcode 1) returns nothing and keeps the block busy: each of the four state
// words needs two 64-bit multiplies, and each multiply takes three passes through the
// single 32x32 multiplier, plus one state per word to form the operand and one final
// state for the all-zero check. req_ready is high only while the sequencer is idle;
// a finished result may still wait in its output register.
module xoshiro256ss_generator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_opcode,
   input  logic [xs256_pkg::WORD_W-1:0]   req_seed_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [xs256_pkg::WORD_W-1:0]   rsp_random_value,
   output logic [xs256_pkg::FRAC_W-1:0]   rsp_uniform_fraction
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DRAW_A,
      ST_DRAW_B,
      ST_SEED_MIX,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_SEED_FIN
   } state_type;

   state_type                       state_ff,  state_in;
   logic [xs256_pkg::WORD_W-1:0]    word0_ff,  word0_in;
   logic [xs256_pkg::WORD_W-1:0]    word1_ff,  word1_in;
   logic [xs256_pkg::WORD_W-1:0]    word2_ff,  word2_in;
   logic [xs256_pkg::WORD_W-1:0]    word3_ff,  word3_in;
   logic [xs256_pkg::WORD_W-1:0]    ctr_ff,    ctr_in;
   logic [xs256_pkg::WORD_W-1:0]    opnd_ff,   opnd_in;
   logic [xs256_pkg::WORD_W-1:0]    acc_ff,    acc_in;
   logic                            step_ff,   step_in;
   logic [1:0]                      idx_ff,    idx_in;
   logic                            any_ff,    any_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [xs256_pkg::WORD_W-1:0]    rsp_value_ff, rsp_value_in;

   logic [xs256_pkg::HALF_W-1:0]    mul_a;
   logic [xs256_pkg::HALF_W-1:0]    mul_b;
   logic [xs256_pkg::WORD_W-1:0]    mul_prod;
   logic [xs256_pkg::WORD_W-1:0]    mul_const;
   logic [xs256_pkg::WORD_W-1:0]    prod_sum;
   logic [xs256_pkg::WORD_W-1:0]    mixed;
   logic [xs256_pkg::WORD_W-1:0]    times5;
   logic [xs256_pkg::WORD_W-1:0]    draw_w2;
   logic [xs256_pkg::WORD_W-1:0]    draw_w3;
   logic                            out_free;

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_random_value     = rsp_value_ff;
   assign rsp_uniform_fraction = rsp_value_ff[xs256_pkg::WORD_W-1:
                                              xs256_pkg::WORD_W-xs256_pkg::FRAC_W];
   assign out_free             = !rsp_valid_ff || rsp_ready;

   // The shared multiplier forms the three partial products that reach the low
   // 64 bits of a 64 by 64 product.
   assign mul_const = step_ff ? xs256_pkg::MIX_MUL_B : xs256_pkg::MIX_MUL_A;

   always_comb begin
      mul_a = opnd_ff[xs256_pkg::HALF_W-1:0];
      mul_b = mul_const[xs256_pkg::HALF_W-1:0];
      case (state_ff)
         ST_MUL1: begin
            mul_b = mul_const[xs256_pkg::WORD_W-1:xs256_pkg::HALF_W];
         end
         ST_MUL2: begin
            mul_a = opnd_ff[xs256_pkg::WORD_W-1:xs256_pkg::HALF_W];
         end
         default: begin
         end
      endcase
   end

   assign mul_prod = {{xs256_pkg::HALF_W{1'b0}}, mul_a} *
                     {{xs256_pkg::HALF_W{1'b0}}, mul_b};
   assign prod_sum = acc_ff + {mul_prod[xs256_pkg::HALF_W-1:0],
                               {xs256_pkg::HALF_W{1'b0}}};
   assign mixed    = step_ff ? (prod_sum ^ (prod_sum >> 31))
                             : (prod_sum ^ (prod_sum >> 27));

   assign times5  = word1_ff + (word1_ff << 2);
   assign draw_w2 = word2_ff ^ word0_ff;
   assign draw_w3 = word3_ff ^ word1_ff;

   always_comb begin
      state_in     = state_ff;
      word0_in     = word0_ff;
      word1_in     = word1_ff;
      word2_in     = word2_ff;
      word3_in     = word3_ff;
      ctr_in       = ctr_ff;
      opnd_in      = opnd_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      any_in       = any_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == xs256_pkg::OP_RESEED) begin
                  ctr_in   = req_seed_value + xs256_pkg::SEED_OFFSET;
                  idx_in   = 2'd0;
                  any_in   = 1'b0;
                  state_in = ST_SEED_MIX;
               end else begin
                  state_in = ST_DRAW_A;
               end
            end
         end
         ST_DRAW_A: begin
            acc_in   = xs256_pkg::rotl7(times5);
            word0_in = word0_ff ^ draw_w3;
            word1_in = word1_ff ^ draw_w2;
            word2_in = draw_w2 ^ (word1_ff << 17);
            word3_in = xs256_pkg::rotl45(draw_w3);
            state_in = ST_DRAW_B;
         end
         ST_DRAW_B: begin
            if (out_free) begin
               rsp_value_in = acc_ff + (acc_ff << 3);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SEED_MIX: begin
            opnd_in  = ctr_ff ^ (ctr_ff >> 30);
            step_in  = 1'b0;
            state_in = ST_MUL0;
         end
         ST_MUL0: begin
            acc_in   = mul_prod;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            acc_in   = prod_sum;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            if (!step_ff) begin
               opnd_in  = mixed;
               step_in  = 1'b1;
               state_in = ST_MUL0;
            end else begin
               case (idx_ff)
                  2'd0:    word0_in = mixed;
                  2'd1:    word1_in = mixed;
                  2'd2:    word2_in = mixed;
                  default: word3_in = mixed;
               endcase
               any_in = any_ff || (mixed != '0);
               ctr_in = ctr_ff + xs256_pkg::GOLDEN_GAMMA;
               idx_in = idx_ff + 2'd1;
               state_in = (idx_ff == 2'd3) ? ST_SEED_FIN : ST_SEED_MIX;
            end
         end
         ST_SEED_FIN: begin
            if (!any_ff) begin
               word0_in = xs256_pkg::GOLDEN_GAMMA;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         word0_ff     <= xs256_pkg::GOLDEN_GAMMA;
         word1_ff     <= xs256_pkg::MIX_MUL_A;
         word2_ff     <= xs256_pkg::MIX_MUL_B;
         word3_ff     <= xs256_pkg::INIT_WORD3;
         step_ff      <= 1'b0;
         idx_ff       <= 2'd0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word0_ff     <= word0_in;
         word1_ff     <= word1_in;
         word2_ff     <= word2_in;
         word3_ff     <= word3_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ctr_ff       <= ctr_in;
      opnd_ff      <= opnd_in;
      acc_ff       <= acc_in;
      rsp_value_ff <= rsp_value_in;
   end

`ifndef SYNTH
   // A new result word appears only when a draw finishes.
   a_rsp_from_draw: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DRAW_B))
      else $error("result word appeared without a finished draw");

   // Between items the generator never rests in the all-zero state.
   a_state_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !((word0_ff == '0) && (word1_ff == '0) &&
                                  (word2_ff == '0) && (word3_ff == '0)))
      else $error("generator state is all zero");

   // An accepted draw word goes straight into the draw sequence.
   a_draw_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == xs256_pkg::OP_DRAW))
         |=> (state_ff == ST_DRAW_A))
      else $error("draw word did not start the draw sequence");

   // The reseed sequence finishes only after the last of the four words.
   a_seed_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEED_FIN) |-> ($past(idx_ff) == 2'd3) && (idx_ff == 2'd0))
      else $error("reseed finished before all four words were mixed");
`endif

endmodule

// ===== tb/xoshiro256ss_generator_tb.sv =====
// Self-checking testbench for xoshiro256ss_generator: drives draw and reseed words through
// the valid/ready channels under several idling and stall patterns and checks every result.
// Depends on xs256_pkg and the xoshiro256ss_generator RTL.

class xs256_expected_draws;
   logic [63:0] st0, st1, st2, st3;
   logic [63:0] upcoming_draws[$];
   int          mismatches;

   function new();
      st0 = xs256_pkg::GOLDEN_GAMMA;
      st1 = xs256_pkg::MIX_MUL_A;
      st2 = xs256_pkg::MIX_MUL_B;
      st3 = xs256_pkg::INIT_WORD3;
      mismatches = 0;
   endfunction

   function logic [63:0] rotate_left(logic [63:0] v, int n);
      return (v << n) | (v >> (64 - n));
   endfunction

   function logic [63:0] scramble(logic [63:0] v);
      v = (v ^ (v >> 30)) * xs256_pkg::MIX_MUL_A;
      v = (v ^ (v >> 27)) * xs256_pkg::MIX_MUL_B;
      return v ^ (v >> 31);
   endfunction

   function void note_word(logic opcode, logic [63:0] seed);
      logic [63:0] counter;
      logic [63:0] seeded[4];
      logic [63:0] value;
      logic [63:0] shifted;
      if (opcode == xs256_pkg::OP_RESEED) begin
         counter = seed + xs256_pkg::GOLDEN_GAMMA;
         for (int i = 0; i < 4; i++) begin
            counter = counter + xs256_pkg::GOLDEN_GAMMA;
            seeded[i] = scramble(counter);
         end
         if ((seeded[0] | seeded[1] | seeded[2] | seeded[3]) == 64'd0)
            seeded[0] = xs256_pkg::GOLDEN_GAMMA;
         st0 = seeded[0];
         st1 = seeded[1];
         st2 = seeded[2];
         st3 = seeded[3];
      end else begin
         value = rotate_left(st1 * 64'd5, 7) * 64'd9;
         shifted = st1 << 17;
         st2 = st2 ^ st0;
         st3 = st3 ^ st1;
         st1 = st1 ^ st2;
         st0 = st0 ^ st3;
         st2 = st2 ^ shifted;
         st3 = rotate_left(st3, 45);
         upcoming_draws.push_back(value);
      end
   endfunction

   function void report(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("Mismatch in %s: expected %h, got %h", what, want, got);
   endfunction

   function void check_draw(logic [63:0] value, logic [52:0] fraction);
      logic [63:0] want;
      if (upcoming_draws.size() == 0) begin
         report("unexpected word", 64'd0, value);
         return;
      end
      want = upcoming_draws.pop_front();
      if (value !== want)
         report("random_value", want, value);
      if (fraction !== want[63:11])
         report("uniform_fraction", {11'd0, want[63:11]}, {11'd0, fraction});
   endfunction
endclass

module xoshiro256ss_generator_tb;

   localparam int LONG_HOLD   = 80;
   localparam int DRAIN_WAIT  = 40;
   localparam int CYCLE_LIMIT = 400000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_opcode = xs256_pkg::OP_DRAW;
   logic [xs256_pkg::WORD_W-1:0]   req_seed_value = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [xs256_pkg::WORD_W-1:0]   rsp_random_value;
   logic [xs256_pkg::FRAC_W-1:0]   rsp_uniform_fraction;

   int                  send_idle_pct = 0;
   int                  recv_stall_pct = 0;
   int                  hold_token = 0;
   int                  hold_seen = 0;
   int                  hold_left = 0;
   int                  cycle_count = 0;

   xs256_expected_draws expected = new();

   xoshiro256ss_generator i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_seed_value       (req_seed_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_random_value     (rsp_random_value),
      .rsp_uniform_fraction (rsp_uniform_fraction)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("xoshiro256ss_generator_tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         expected.check_draw(rsp_random_value, rsp_uniform_fraction);
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic send_word(input logic opcode, input logic [xs256_pkg::WORD_W-1:0] seed);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= opcode;
      req_seed_value <= seed;
      do
         @(posedge clock);
      while (!req_ready);
      expected.note_word(opcode, seed);
   endtask

   task automatic wait_for_draws();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected.upcoming_draws.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [xs256_pkg::WORD_W-1:0] zeroing_seed(input int steps);
      logic [xs256_pkg::WORD_W-1:0] seed;
      seed = '0;
      repeat (steps) seed = seed - xs256_pkg::GOLDEN_GAMMA;
      return seed;
   endfunction

   function automatic logic [xs256_pkg::WORD_W-1:0] random_seed();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic run_random(input int count, input int idle_pct, input int stall_pct,
                             input bit with_pressure);
      send_idle_pct = idle_pct;
      recv_stall_pct <= stall_pct;
      for (int i = 0; i < count; i++) begin
         if (with_pressure && i == count / 4)
            hold_token <= hold_token + 1;
         if (with_pressure && i == count / 2)
            wait_for_draws();
         if ($urandom_range(0, 99) < 10)
            send_word(xs256_pkg::OP_RESEED, random_seed());
         else
            send_word(xs256_pkg::OP_DRAW, {$urandom(), $urandom()});
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(xs256_pkg::OP_DRAW, '0);
      send_word(xs256_pkg::OP_DRAW, '1);
      send_word(xs256_pkg::OP_DRAW, {$urandom(), $urandom()});
      send_word(xs256_pkg::OP_RESEED, '0);
      send_word(xs256_pkg::OP_DRAW, '1);
      send_word(xs256_pkg::OP_DRAW, '0);
      send_word(xs256_pkg::OP_RESEED, '1);
      send_word(xs256_pkg::OP_DRAW, '0);
      for (int k = 2; k <= 5; k++) begin
         send_word(xs256_pkg::OP_RESEED, zeroing_seed(k));
         send_word(xs256_pkg::OP_DRAW, '1);
         send_word(xs256_pkg::OP_DRAW, '0);
      end
      send_word(xs256_pkg::OP_RESEED, {$urandom(), $urandom()});
      send_word(xs256_pkg::OP_RESEED, {$urandom(), $urandom()});
      send_word(xs256_pkg::OP_DRAW, '0);
      wait_for_draws();

      run_random(300, 0, 0, 1'b1);
      run_random(300, 78, 0, 1'b0);
      run_random(300, 0, 78, 1'b1);
      run_random(300, 18, 18, 1'b0);

      wait_for_draws();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected.mismatches == 0 && expected.upcoming_draws.size() == 0)
         $display("xoshiro256ss_generator_tb OK");
      else
         $display("xoshiro256ss_generator_tb NOT OK");
      $finish;
   end
endmodule
